// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define FDAC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("deframer assertion failed");

// next-cycle implication, off during reset
`define FDAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("deframer assertion failed");

`endif

// ----- rtl/core/fdac_pkg.sv -----
// ----------------------------------------------------------------------------
// fdac_pkg
// Types and constants of the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fdac_pkg;

	localparam int unsigned LENGTH_BITS = 16;
	localparam logic [31:0] LENGTH_CAP = 32'((64'd1 << LENGTH_BITS) - 64'd1);

	localparam logic [7:0]  HDR_FIRST        = 8'hFF;
	localparam logic [7:0]  HDR_SECOND       = 8'hFE;
	localparam logic [31:0] LEN_OVERHEAD     = 32'd4;
	localparam logic [15:0] MAX_LENGTH_RESET = 16'd4090;

	typedef enum logic [3:0] {
		PH_HUNT1 = 4'd0,
		PH_HUNT2 = 4'd1,
		PH_LEN0  = 4'd2,
		PH_LEN1  = 4'd3,
		PH_LEN2  = 4'd4,
		PH_LEN3  = 4'd5,
		PH_CMD0  = 4'd6,
		PH_CMD1  = 4'd7,
		PH_DATA  = 4'd8,
		PH_SUM0  = 4'd9,
		PH_SUM1  = 4'd10
	} phase_t;

	typedef enum logic [1:0] {
		EV_PAYLOAD  = 2'd0,
		EV_GOOD     = 2'd1,
		EV_MISMATCH = 2'd2,
		EV_BADLEN   = 2'd3
	} event_kind_t;

endpackage

// ----- rtl/core/frame_deframer_additive_checksum.sv -----
// ----------------------------------------------------------------------------
// frame_deframer_additive_checksum
// Byte-serial parser for 0xFEFF-headed, length-prefixed frames with a 16-bit
// additive payload checksum.
// ----------------------------------------------------------------------------
// Takes one byte per clock when the output is not stalled. Each byte is
// decoded against the frame phase in the cycle it is transferred, and any
// event it causes (payload byte, frame good, checksum mismatch, bad length)
// appears in the output register on the next cycle. The output register is
// the only stage, so throughput is one byte per cycle while it is not stalled;
// in_stall follows out_stall only while a result is held. max_length may be
// written at any time the parser is idle; cfg_ready is always high.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frame_deframer_additive_checksum (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_kind,
	output logic [7:0]  payload_byte,
	output logic [15:0] command,
	output logic [15:0] payload_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	fdac_pkg::phase_t      phase_q, phase_d;
	logic [15:0]           max_len_q;
	logic [23:0]           len_q, len_d;
	logic [15:0]           count_q, count_d;
	logic [15:0]           left_q, left_d;
	logic [15:0]           cmd_q, cmd_d;
	logic [15:0]           sum_q, sum_d;
	logic [7:0]            csum_lo_q, csum_lo_d;

	logic                  in_xfer;
	logic [31:0]           len_full;
	logic [31:0]           len_body;
	logic [31:0]           limit;

	logic                  res_valid;
	fdac_pkg::event_kind_t res_kind;
	logic [7:0]            res_byte;
	logic [15:0]           res_cmd;
	logic [15:0]           res_count;

	logic                  out_valid_q;
	fdac_pkg::event_kind_t kind_q;
	logic [7:0]            byte_q;
	logic [15:0]           ocmd_q;
	logic [15:0]           ocount_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q & out_stall;
	assign in_xfer   = in_valid & ~in_stall;

	assign len_full = {rx_byte, len_q};
	assign len_body = len_full - fdac_pkg::LEN_OVERHEAD;
	assign limit    = ({16'd0, max_len_q} < fdac_pkg::LENGTH_CAP) ?
		{16'd0, max_len_q} : fdac_pkg::LENGTH_CAP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= fdac_pkg::MAX_LENGTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= fdac_pkg::PH_HUNT1;
			len_q     <= '0;
			count_q   <= '0;
			left_q    <= '0;
			cmd_q     <= '0;
			sum_q     <= '0;
			csum_lo_q <= '0;
		end else if (in_xfer) begin
			phase_q   <= phase_d;
			len_q     <= len_d;
			count_q   <= count_d;
			left_q    <= left_d;
			cmd_q     <= cmd_d;
			sum_q     <= sum_d;
			csum_lo_q <= csum_lo_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		len_d     = len_q;
		count_d   = count_q;
		left_d    = left_q;
		cmd_d     = cmd_q;
		sum_d     = sum_q;
		csum_lo_d = csum_lo_q;
		res_valid = 1'b0;
		res_kind  = fdac_pkg::EV_PAYLOAD;
		res_byte  = '0;
		res_cmd   = '0;
		res_count = '0;
		unique case (phase_q)
			fdac_pkg::PH_HUNT2: begin
				if (rx_byte == fdac_pkg::HDR_SECOND) begin
					phase_d = fdac_pkg::PH_LEN0;
				end else if (rx_byte != fdac_pkg::HDR_FIRST) begin
					phase_d = fdac_pkg::PH_HUNT1;
				end
			end
			fdac_pkg::PH_LEN0: begin
				len_d   = {16'd0, rx_byte};
				phase_d = fdac_pkg::PH_LEN1;
			end
			fdac_pkg::PH_LEN1: begin
				len_d[15:8] = rx_byte;
				phase_d     = fdac_pkg::PH_LEN2;
			end
			fdac_pkg::PH_LEN2: begin
				len_d[23:16] = rx_byte;
				phase_d      = fdac_pkg::PH_LEN3;
			end
			fdac_pkg::PH_LEN3: begin
				if (len_full < fdac_pkg::LEN_OVERHEAD || len_full > limit) begin
					phase_d   = fdac_pkg::PH_HUNT1;
					res_valid = 1'b1;
					res_kind  = fdac_pkg::EV_BADLEN;
				end else begin
					left_d  = len_body[15:0];
					count_d = len_body[15:0];
					phase_d = fdac_pkg::PH_CMD0;
				end
			end
			fdac_pkg::PH_CMD0: begin
				cmd_d   = {8'd0, rx_byte};
				phase_d = fdac_pkg::PH_CMD1;
			end
			fdac_pkg::PH_CMD1: begin
				cmd_d[15:8] = rx_byte;
				sum_d       = '0;
				phase_d     = (left_q == 16'd0) ? fdac_pkg::PH_SUM0 : fdac_pkg::PH_DATA;
			end
			fdac_pkg::PH_DATA: begin
				sum_d  = sum_q + {8'd0, rx_byte};
				left_d = left_q - 16'd1;
				if (left_d == 16'd0) begin
					phase_d = fdac_pkg::PH_SUM0;
				end
				res_valid = 1'b1;
				res_kind  = fdac_pkg::EV_PAYLOAD;
				res_byte  = rx_byte;
				res_cmd   = cmd_q;
			end
			fdac_pkg::PH_SUM0: begin
				csum_lo_d = rx_byte;
				phase_d   = fdac_pkg::PH_SUM1;
			end
			fdac_pkg::PH_SUM1: begin
				phase_d   = fdac_pkg::PH_HUNT1;
				res_valid = 1'b1;
				res_kind  = ({rx_byte, csum_lo_q} == sum_q) ?
					fdac_pkg::EV_GOOD : fdac_pkg::EV_MISMATCH;
				res_cmd   = cmd_q;
				res_count = count_q;
			end
			default: begin
				phase_d = (rx_byte == fdac_pkg::HDR_FIRST) ?
					fdac_pkg::PH_HUNT2 : fdac_pkg::PH_HUNT1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && res_valid) begin
			kind_q   <= res_kind;
			byte_q   <= res_byte;
			ocmd_q   <= res_cmd;
			ocount_q <= res_count;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_kind    = kind_q;
	assign payload_byte  = byte_q;
	assign command       = ocmd_q;
	assign payload_count = ocount_q;

	`FDAC_ASSERT_IMPLIES(a_data_has_bytes, clk, arst_n,
		phase_q == fdac_pkg::PH_DATA, left_q != 16'd0)
	`FDAC_ASSERT_NEXT(a_data_emits_payload, clk, arst_n,
		in_xfer && phase_q == fdac_pkg::PH_DATA,
		out_valid_q && kind_q == fdac_pkg::EV_PAYLOAD)
	`FDAC_ASSERT_NEXT(a_quiet_phase_no_event, clk, arst_n,
		in_xfer && (phase_q == fdac_pkg::PH_HUNT2 || phase_q == fdac_pkg::PH_LEN0 ||
		phase_q == fdac_pkg::PH_CMD0 || phase_q == fdac_pkg::PH_CMD1 ||
		phase_q == fdac_pkg::PH_SUM0), !out_valid_q)
	`FDAC_ASSERT_IMPLIES(a_badlen_clean, clk, arst_n,
		out_valid_q && kind_q == fdac_pkg::EV_BADLEN,
		ocmd_q == 16'd0 && ocount_q == 16'd0)

endmodule

// ----- test/frame_deframer_additive_checksum_test.sv -----
// ----------------------------------------------------------------------------
// frame_deframer_additive_checksum_test
// Self-checking bench for the 0xFEFF length-prefixed frame deframer.
// ----------------------------------------------------------------------------
// A queue of planned transfers (bytes, max_length writes, pacing changes and
// waits for an empty scoreboard) feeds a clocked driver. A clocked monitor
// tracks the frame phase of every accepted byte, predicts the event it causes
// and checks each output transfer field by field against the oldest
// prediction. Directed frames come first, then random well-formed frames mixed
// with bad lengths, broken headers and noise under several max_length values
// and back-pressure patterns.
`timescale 1ns / 1ps

module frame_deframer_additive_checksum_test;

	localparam int SETTLE_CYCLES = 3;
	localparam int TAIL_CYCLES   = 8;

	typedef enum logic [1:0] {
		OP_BYTE,
		OP_WRITE_MAX,
		OP_WAIT_EMPTY,
		OP_PACE
	} plan_op_t;

	typedef struct packed {
		plan_op_t    op;
		logic [15:0] value;
	} plan_item_t;

	typedef struct packed {
		fdac_pkg::event_kind_t kind;
		logic [7:0]            data;
		logic [15:0]           cmd;
		logic [15:0]           count;
	} frame_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  event_kind;
	logic [7:0]  payload_byte;
	logic [15:0] command;
	logic [15:0] payload_count;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'd0;

	plan_item_t   tx_plan[$];
	frame_event_t expected_events[$];

	int          send_gap_pct = 0;
	int          recv_stall_pct = 0;
	int          quiet = 0;
	int          backlog = 0;
	int          planned_bytes = 0;
	logic [15:0] plan_max = fdac_pkg::MAX_LENGTH_RESET;

	int mismatches = 0;
	int bytes_in = 0;
	int max_writes = 0;
	int payload_events = 0;
	int good_frames = 0;
	int bad_sums = 0;
	int bad_lengths = 0;

	// frame tracker state
	fdac_pkg::phase_t rx_phase;
	logic [31:0]      len_field;
	logic [15:0]      remaining;
	logic [15:0]      cmd_field;
	logic [15:0]      payload_sum;
	logic [7:0]       sum_low;
	logic [15:0]      max_len_reg;

	frame_deframer_additive_checksum i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.event_kind    (event_kind),
		.payload_byte  (payload_byte),
		.command       (command),
		.payload_count (payload_count),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	task automatic deframe_byte(input logic [7:0] b);
		logic [31:0]  ceiling;
		frame_event_t ev;
		ceiling = ({16'd0, max_len_reg} < fdac_pkg::LENGTH_CAP) ?
			{16'd0, max_len_reg} : fdac_pkg::LENGTH_CAP;
		ev = '{kind: fdac_pkg::EV_PAYLOAD, data: 8'd0, cmd: 16'd0, count: 16'd0};
		case (rx_phase)
		fdac_pkg::PH_HUNT2: begin
			if (b == fdac_pkg::HDR_SECOND)
				rx_phase = fdac_pkg::PH_LEN0;
			else if (b != fdac_pkg::HDR_FIRST)
				rx_phase = fdac_pkg::PH_HUNT1;
		end
		fdac_pkg::PH_LEN0: begin
			len_field = {24'd0, b};
			rx_phase = fdac_pkg::PH_LEN1;
		end
		fdac_pkg::PH_LEN1: begin
			len_field[15:8] = b;
			rx_phase = fdac_pkg::PH_LEN2;
		end
		fdac_pkg::PH_LEN2: begin
			len_field[23:16] = b;
			rx_phase = fdac_pkg::PH_LEN3;
		end
		fdac_pkg::PH_LEN3: begin
			len_field[31:24] = b;
			if (len_field < fdac_pkg::LEN_OVERHEAD || len_field > ceiling) begin
				rx_phase = fdac_pkg::PH_HUNT1;
				ev.kind = fdac_pkg::EV_BADLEN;
				expected_events.push_back(ev);
			end else begin
				remaining = 16'(len_field - fdac_pkg::LEN_OVERHEAD);
				rx_phase = fdac_pkg::PH_CMD0;
			end
		end
		fdac_pkg::PH_CMD0: begin
			cmd_field = {8'd0, b};
			rx_phase = fdac_pkg::PH_CMD1;
		end
		fdac_pkg::PH_CMD1: begin
			cmd_field[15:8] = b;
			payload_sum = 16'd0;
			rx_phase = (remaining == 16'd0) ? fdac_pkg::PH_SUM0 : fdac_pkg::PH_DATA;
		end
		fdac_pkg::PH_DATA: begin
			payload_sum = payload_sum + {8'd0, b};
			remaining = remaining - 16'd1;
			if (remaining == 16'd0)
				rx_phase = fdac_pkg::PH_SUM0;
			ev.data = b;
			ev.cmd = cmd_field;
			expected_events.push_back(ev);
		end
		fdac_pkg::PH_SUM0: begin
			sum_low = b;
			rx_phase = fdac_pkg::PH_SUM1;
		end
		fdac_pkg::PH_SUM1: begin
			ev.kind = ({b, sum_low} == payload_sum) ?
				fdac_pkg::EV_GOOD : fdac_pkg::EV_MISMATCH;
			ev.cmd = cmd_field;
			ev.count = 16'(len_field - fdac_pkg::LEN_OVERHEAD);
			rx_phase = fdac_pkg::PH_HUNT1;
			expected_events.push_back(ev);
		end
		default: rx_phase = (b == fdac_pkg::HDR_FIRST) ?
			fdac_pkg::PH_HUNT2 : fdac_pkg::PH_HUNT1;
		endcase
	endtask

	task automatic plan_byte(input logic [7:0] b);
		tx_plan.push_back('{op: OP_BYTE, value: {8'd0, b}});
		planned_bytes++;
	endtask

	task automatic plan_write_max(input logic [15:0] v);
		tx_plan.push_back('{op: OP_WRITE_MAX, value: v});
		plan_max = v;
	endtask

	task automatic plan_pace(input int send_gap, input int recv_stall);
		tx_plan.push_back('{op: OP_PACE, value: {8'(send_gap), 8'(recv_stall)}});
	endtask

	task automatic plan_length_only(input logic [31:0] len);
		plan_byte(fdac_pkg::HDR_FIRST);
		plan_byte(fdac_pkg::HDR_SECOND);
		for (int i = 0; i < 4; i++)
			plan_byte(len[8*i +: 8]);
	endtask

	task automatic plan_frame(input logic [15:0] cmd, input int n, input bit corrupt);
		logic [15:0] sum;
		logic [7:0]  b;
		sum = 16'd0;
		plan_length_only(32'(n) + fdac_pkg::LEN_OVERHEAD);
		plan_byte(cmd[7:0]);
		plan_byte(cmd[15:8]);
		for (int i = 0; i < n; i++) begin
			b = 8'($urandom);
			sum = sum + {8'd0, b};
			plan_byte(b);
		end
		if (corrupt)
			sum = sum ^ (16'd1 << $urandom_range(15));
		plan_byte(sum[7:0]);
		plan_byte(sum[15:8]);
	endtask

	task automatic plan_random(input int n_bytes);
		int          stop_at;
		int          pick;
		int          top;
		logic [31:0] ceiling;
		stop_at = planned_bytes + n_bytes;
		ceiling = ({16'd0, plan_max} < fdac_pkg::LENGTH_CAP) ?
			{16'd0, plan_max} : fdac_pkg::LENGTH_CAP;
		while (planned_bytes < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 72) begin
				if (ceiling < fdac_pkg::LEN_OVERHEAD)
					top = 8;
				else
					top = (ceiling - fdac_pkg::LEN_OVERHEAD > 60) ?
						60 : int'(ceiling - fdac_pkg::LEN_OVERHEAD);
				plan_frame(16'($urandom),
					($urandom_range(7) == 0) ? top : $urandom_range(top < 16 ? top : 16),
					$urandom_range(3) == 0);
			end else if (pick < 84) begin
				case ($urandom_range(2))
				0: plan_length_only($urandom_range(3));
				1: plan_length_only(ceiling + 32'd1);
				default: plan_length_only($urandom | 32'h0001_0000);
				endcase
			end else if (pick < 94) begin
				repeat ($urandom_range(6, 1)) begin
					case ($urandom_range(5))
					0, 1: plan_byte(fdac_pkg::HDR_FIRST);
					2: plan_byte(fdac_pkg::HDR_SECOND);
					default: plan_byte(8'($urandom));
					endcase
				end
			end else begin
				plan_byte(fdac_pkg::HDR_FIRST);
				plan_byte(8'($urandom_range(253)));
			end
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		logic next_in;
		logic next_cfg;
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'd0;
			cfg_valid <= 1'b0;
			cfg_data <= 16'd0;
			quiet <= 0;
		end else begin
			quiet <= (in_valid && !in_stall) ? 0 : (quiet < 15 ? quiet + 1 : quiet);
			next_in = in_valid && in_stall;
			next_cfg = cfg_valid && !cfg_ready;
			if (!next_in && !next_cfg && tx_plan.size() != 0) begin
				case (tx_plan[0].op)
				OP_BYTE: begin
					if ($urandom_range(99) >= send_gap_pct) begin
						next_in = 1'b1;
						rx_byte <= tx_plan[0].value[7:0];
						tx_plan.delete(0);
					end
				end
				OP_WRITE_MAX: begin
					if (!in_valid && backlog == 0 && quiet >= SETTLE_CYCLES) begin
						next_cfg = 1'b1;
						cfg_data <= tx_plan[0].value;
						tx_plan.delete(0);
					end
				end
				OP_WAIT_EMPTY: begin
					if (!in_valid && backlog == 0)
						tx_plan.delete(0);
				end
				default: begin
					send_gap_pct <= int'(tx_plan[0].value[15:8]);
					recv_stall_pct <= int'(tx_plan[0].value[7:0]);
					tx_plan.delete(0);
				end
				endcase
			end
			in_valid <= next_in;
			cfg_valid <= next_cfg;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		frame_event_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			backlog <= 0;
			expected_events.delete();
			rx_phase = fdac_pkg::PH_HUNT1;
			len_field = 32'd0;
			remaining = 16'd0;
			cmd_field = 16'd0;
			payload_sum = 16'd0;
			sum_low = 8'd0;
			max_len_reg = fdac_pkg::MAX_LENGTH_RESET;
		end else begin
			if (out_valid && !out_stall) begin
				case (event_kind)
				fdac_pkg::EV_PAYLOAD: payload_events++;
				fdac_pkg::EV_GOOD: good_frames++;
				fdac_pkg::EV_MISMATCH: bad_sums++;
				default: bad_lengths++;
				endcase
				if (expected_events.size() == 0) begin
					$error("unexpected event transfer: event_kind %0d", event_kind);
					mismatches++;
				end else begin
					want = expected_events.pop_front();
					if (event_kind !== want.kind) begin
						$error("event_kind: expected %0d, got %0d", want.kind, event_kind);
						mismatches++;
					end
					if (payload_byte !== want.data) begin
						$error("payload_byte: expected 0x%02h, got 0x%02h", want.data,
							payload_byte);
						mismatches++;
					end
					if (command !== want.cmd) begin
						$error("command: expected 0x%04h, got 0x%04h", want.cmd, command);
						mismatches++;
					end
					if (payload_count !== want.count) begin
						$error("payload_count: expected %0d, got %0d", want.count,
							payload_count);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				max_len_reg = cfg_data;
				max_writes++;
			end
			if (in_valid && !in_stall) begin
				deframe_byte(rx_byte);
				bytes_in++;
			end
			backlog <= expected_events.size();
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		plan_pace(7, 64);
		// broken header, then a repeated first header byte opens an empty frame
		plan_byte(fdac_pkg::HDR_FIRST);
		plan_byte(8'h00);
		plan_byte(fdac_pkg::HDR_FIRST);
		plan_frame(16'hFFFF, 0, 1'b0);
		plan_length_only(32'd3);
		plan_frame(16'h0000, 1, 1'b1);

		plan_write_max(fdac_pkg::MAX_LENGTH_RESET);
		plan_random(160);
		tx_plan.push_back('{op: OP_WAIT_EMPTY, value: 16'd0});
		plan_random(40);
		plan_write_max(16'd4);
		plan_random(50);

		plan_pace(64, 7);
		plan_write_max(16'hFFFF);
		plan_random(160);
		plan_write_max(16'd0);
		plan_random(30);

		plan_pace(0, 0);
		plan_write_max(16'($urandom_range(40, 9)));
		plan_random(120);
		tx_plan.push_back('{op: OP_WAIT_EMPTY, value: 16'd0});
		plan_write_max(fdac_pkg::MAX_LENGTH_RESET);
		plan_random(60);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (tx_plan.size() != 0 || in_valid || cfg_valid || backlog != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (expected_events.size() != 0) begin
			$error("%0d expected events never arrived", expected_events.size());
			mismatches++;
		end

		$display("covered %0d bytes and %0d max_length writes over three pacing modes",
			bytes_in, max_writes);
		$display("events seen: %0d payload, %0d good, %0d checksum error, %0d bad length",
			payload_events, good_frames, bad_sums, bad_lengths);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
